// ===== src/i2c_ras_pkg.sv =====
// i2c register access sequencer: shared types and constants
// no dependencies; used by the top level and its checker

package i2c_ras_pkg;

   localparam int IDX_WIDTH = 16;
   localparam int BYTE_WIDTH = 8;

   typedef enum logic [1:0] {
      OP_START_WRITE = 2'd0,
      OP_START_READ  = 2'd1,
      OP_BUS_EVENT   = 2'd2
   } opcode_type;

   typedef enum logic [2:0] {
      EV_START_SENT        = 3'd0,
      EV_TX_SELECTED       = 3'd1,
      EV_BYTE_TRANSMITTING = 3'd2,
      EV_BYTE_TRANSMITTED  = 3'd3,
      EV_RX_SELECTED       = 3'd4,
      EV_BYTE_RECEIVED     = 3'd5,
      EV_OTHER             = 3'd6
   } event_type;

   typedef enum logic [1:0] {
      ACT_NONE       = 2'd0,
      ACT_SEND_ADDR  = 2'd1,
      ACT_SEND_DATA  = 2'd2,
      ACT_STORE_BYTE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      IRQ_OFF          = 2'd0,
      IRQ_EVENT        = 2'd1,
      IRQ_EVENT_BUFFER = 2'd2
   } irq_type;

   typedef struct packed {
      logic                  accepted;
      action_type            action;
      logic                  direction;
      logic [BYTE_WIDTH-1:0] data_value;
      logic                  gen_start;
      logic                  gen_stop;
      logic                  ack_on;
      irq_type               irq_mode;
      logic [IDX_WIDTH-1:0]  byte_index;
      logic                  done_res;
      logic                  busy_res;
   } rsp_type;

endpackage

// ===== src/i2c_register_access_sequencer.sv =====
// i2c register access sequencer: event driven master for register writes and reads
// depends on i2c_ras_pkg
//
//   channel  | ports                         | direction
//   ---------+-------------------------------+----------
//   request  | req_valid, req_stall, req_*   | in
//   response | rsp_valid, rsp_stall, rsp_*   | out
//
// the next state and the response are formed from the request ports and the
// state registers and land in the response register, or in the skid register
// while that is stalled; one response per item, one item per cycle sustained
// while rsp_stall stays low; a skid register takes one item while the response
// register is stalled; req_stall is high only while that skid register is full
// synchronous reset clears the sequencer state and both valid flags

module i2c_register_access_sequencer #(
   parameter int LEN_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_device_addr,
   input  logic [7:0]  req_reg_addr,
   input  logic [15:0] req_length,
   input  logic [2:0]  req_event_kind,
   input  logic [7:0]  req_tx_byte,
   input  logic [7:0]  req_rx_byte,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_accepted,
   output logic [1:0]  rsp_action,
   output logic        rsp_direction,
   output logic [7:0]  rsp_data_value,
   output logic        rsp_gen_start,
   output logic        rsp_gen_stop,
   output logic        rsp_ack_on,
   output logic [1:0]  rsp_irq_mode,
   output logic [15:0] rsp_byte_index,
   output logic        rsp_done_res,
   output logic        rsp_busy_res
);

   logic                  busy_ff, busy_in;
   logic                  rx_phase_ff, rx_phase_in;
   logic                  is_read_ff, is_read_in;
   logic [7:0]            slave_addr_ff, slave_addr_in;
   logic [7:0]            target_reg_ff, target_reg_in;
   logic [LEN_WIDTH-1:0]  byte_count_ff, byte_count_in;
   logic [LEN_WIDTH-1:0]  byte_pos_ff, byte_pos_in;
   logic                  ack_ff, ack_in;
   i2c_ras_pkg::irq_type  irq_ff, irq_in;

   i2c_ras_pkg::rsp_type  out_ff, skid_ff, result;
   logic                  out_vld_ff, skid_vld_ff;

   logic                  accept;
   logic                  out_free;
   logic [LEN_WIDTH-1:0]  len;
   logic [LEN_WIDTH-1:0]  last;
   logic [LEN_WIDTH-1:0]  pos_inc;
   logic [LEN_WIDTH-1:0]  idx;

   assign req_stall = skid_vld_ff;
   assign accept    = req_valid && !skid_vld_ff;
   assign out_free  = !out_vld_ff || !rsp_stall;

   assign len     = req_length[LEN_WIDTH-1:0];
   assign last    = LEN_WIDTH'(byte_count_ff - 1'b1);
   assign pos_inc = LEN_WIDTH'(byte_pos_ff + 1'b1);

   always_comb begin
      busy_in       = busy_ff;
      rx_phase_in   = rx_phase_ff;
      is_read_in    = is_read_ff;
      slave_addr_in = slave_addr_ff;
      target_reg_in = target_reg_ff;
      byte_count_in = byte_count_ff;
      byte_pos_in   = byte_pos_ff;
      ack_in        = ack_ff;
      irq_in        = irq_ff;
      idx           = '0;
      result        = '0;

      case (i2c_ras_pkg::opcode_type'(req_opcode))
         i2c_ras_pkg::OP_START_WRITE, i2c_ras_pkg::OP_START_READ: begin
            if (!busy_ff && len != '0) begin
               result.accepted  = 1'b1;
               result.gen_start = 1'b1;
               busy_in          = 1'b1;
               rx_phase_in      = 1'b0;
               is_read_in       = (req_opcode == i2c_ras_pkg::OP_START_READ);
               slave_addr_in    = req_device_addr;
               target_reg_in    = req_reg_addr;
               byte_count_in    = len;
               byte_pos_in      = '0;
               ack_in           = 1'b1;
               irq_in           = i2c_ras_pkg::IRQ_EVENT_BUFFER;
            end
         end
         i2c_ras_pkg::OP_BUS_EVENT: begin
            if (busy_ff && !rx_phase_ff) begin
               case (i2c_ras_pkg::event_type'(req_event_kind))
                  i2c_ras_pkg::EV_START_SENT: begin
                     result.action     = i2c_ras_pkg::ACT_SEND_ADDR;
                     result.data_value = {slave_addr_ff[7:1], 1'b0};
                  end
                  i2c_ras_pkg::EV_TX_SELECTED: begin
                     result.action     = i2c_ras_pkg::ACT_SEND_DATA;
                     result.data_value = target_reg_ff;
                  end
                  i2c_ras_pkg::EV_BYTE_TRANSMITTING: begin
                     if (byte_pos_ff < byte_count_ff && !is_read_ff) begin
                        result.action     = i2c_ras_pkg::ACT_SEND_DATA;
                        result.data_value = req_tx_byte;
                        idx               = byte_pos_ff;
                        byte_pos_in       = pos_inc;
                     end else begin
                        irq_in = i2c_ras_pkg::IRQ_EVENT;
                     end
                  end
                  i2c_ras_pkg::EV_BYTE_TRANSMITTED: begin
                     if (is_read_ff) begin
                        rx_phase_in      = 1'b1;
                        irq_in           = i2c_ras_pkg::IRQ_EVENT_BUFFER;
                        result.gen_start = 1'b1;
                     end else begin
                        irq_in          = i2c_ras_pkg::IRQ_OFF;
                        ack_in          = 1'b0;
                        busy_in         = 1'b0;
                        result.gen_stop = 1'b1;
                        result.done_res = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end else if (busy_ff) begin
               case (i2c_ras_pkg::event_type'(req_event_kind))
                  i2c_ras_pkg::EV_START_SENT: begin
                     result.action     = i2c_ras_pkg::ACT_SEND_ADDR;
                     result.direction  = 1'b1;
                     result.data_value = {slave_addr_ff[7:1], 1'b1};
                  end
                  i2c_ras_pkg::EV_RX_SELECTED: begin
                     if (byte_pos_ff == last) begin
                        ack_in          = 1'b0;
                        result.gen_stop = 1'b1;
                     end
                  end
                  i2c_ras_pkg::EV_BYTE_RECEIVED: begin
                     result.action     = i2c_ras_pkg::ACT_STORE_BYTE;
                     result.data_value = req_rx_byte;
                     idx               = byte_pos_ff;
                     byte_pos_in       = pos_inc;
                     if (pos_inc == last) begin
                        ack_in          = 1'b0;
                        result.gen_stop = 1'b1;
                     end else if (pos_inc >= byte_count_ff) begin
                        rx_phase_in     = 1'b0;
                        irq_in          = i2c_ras_pkg::IRQ_OFF;
                        busy_in         = 1'b0;
                        result.done_res = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
         end
      endcase

      result.byte_index = i2c_ras_pkg::IDX_WIDTH'(idx);
      result.ack_on     = ack_in;
      result.irq_mode   = irq_in;
      result.busy_res   = busy_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         rx_phase_ff   <= 1'b0;
         is_read_ff    <= 1'b0;
         slave_addr_ff <= '0;
         target_reg_ff <= '0;
         byte_count_ff <= '0;
         byte_pos_ff   <= '0;
         ack_ff        <= 1'b0;
         irq_ff        <= i2c_ras_pkg::IRQ_OFF;
      end else if (accept) begin
         busy_ff       <= busy_in;
         rx_phase_ff   <= rx_phase_in;
         is_read_ff    <= is_read_in;
         slave_addr_ff <= slave_addr_in;
         target_reg_ff <= target_reg_in;
         byte_count_ff <= byte_count_in;
         byte_pos_ff   <= byte_pos_in;
         ack_ff        <= ack_in;
         irq_ff        <= irq_in;
      end
   end

   // response register with one skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_vld_ff) begin
            out_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end else begin
            out_vld_ff <= accept;
         end
      end else if (accept) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_vld_ff) begin
            out_ff <= skid_ff;
         end else if (accept) begin
            out_ff <= result;
         end
      end else if (accept) begin
         skid_ff <= result;
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_accepted   = out_ff.accepted;
   assign rsp_action     = out_ff.action;
   assign rsp_direction  = out_ff.direction;
   assign rsp_data_value = out_ff.data_value;
   assign rsp_gen_start  = out_ff.gen_start;
   assign rsp_gen_stop   = out_ff.gen_stop;
   assign rsp_ack_on     = out_ff.ack_on;
   assign rsp_irq_mode   = out_ff.irq_mode;
   assign rsp_byte_index = out_ff.byte_index;
   assign rsp_done_res   = out_ff.done_res;
   assign rsp_busy_res   = out_ff.busy_res;

endmodule

// ===== src/i2c_ras_checker.sv =====
// i2c register access sequencer: port level checks over time
// depends on i2c_ras_pkg; bound to i2c_register_access_sequencer below

module i2c_ras_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_accepted,
   input logic [1:0]  rsp_action,
   input logic        rsp_direction,
   input logic [7:0]  rsp_data_value,
   input logic        rsp_gen_start,
   input logic        rsp_ack_on,
   input logic [1:0]  rsp_irq_mode,
   input logic        rsp_done_res,
   input logic        rsp_busy_res
);

   // a taken start command opens a transaction with ack and both interrupts on
   a_start_setup: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |->
         rsp_gen_start && rsp_busy_res && rsp_ack_on &&
         rsp_irq_mode == i2c_ras_pkg::IRQ_EVENT_BUFFER)
      else $error("start item without full setup");

   // finishing a transaction leaves the block idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res && !rsp_accepted)
      else $error("done item still busy");

   // direction bit only accompanies an address byte and matches its low bit
   a_dir_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_direction |->
         rsp_action == i2c_ras_pkg::ACT_SEND_ADDR && rsp_data_value[0])
      else $error("direction without address");

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data_value) &&
         $stable(rsp_action))
      else $error("stalled item changed");

   // an item taken while the response is held fills the skid entry
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall && req_valid && !req_stall |=> req_stall)
      else $error("item taken under stall without skid");

endmodule

bind i2c_register_access_sequencer i2c_ras_checker u_i2c_ras_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_accepted   (rsp_accepted),
   .rsp_action     (rsp_action),
   .rsp_direction  (rsp_direction),
   .rsp_data_value (rsp_data_value),
   .rsp_gen_start  (rsp_gen_start),
   .rsp_ack_on     (rsp_ack_on),
   .rsp_irq_mode   (rsp_irq_mode),
   .rsp_done_res   (rsp_done_res),
   .rsp_busy_res   (rsp_busy_res)
);
